[design/scan_nearest_target_follower_assert.svh]
// Assertion macros for the nearest-target follower checker.
// Used by snt_checker.sv only; needs no package.
`ifndef SCAN_NEAREST_TARGET_FOLLOWER_ASSERT_SVH
`define SCAN_NEAREST_TARGET_FOLLOWER_ASSERT_SVH

// same-cycle implication
`define SNT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("snt assertion failed");

// next-cycle implication
`define SNT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("snt assertion failed");

`endif

[design/snt_pkg.sv]
// Shared constants and widths for the nearest-target follower.
// No dependencies.
`default_nettype none
package snt_pkg;

  localparam int SCAN_LEN  = 360;
  localparam int IDX_W     = $clog2(SCAN_LEN + 1);
  localparam int ANG_W     = IDX_W;
  localparam int DIST_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int OPEN_W    = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int SQ_SHIFT  = 10;
  localparam int RAD_W     = DIST_W + SQ_SHIFT;
  localparam int ROOT_W    = (RAD_W + 1) / 2;
  localparam int REM_W     = ROOT_W + 1;
  localparam int PROD_W    = GAIN_W + ROOT_W;
  localparam int STEP_W    = $clog2(ROOT_W + 1);
  localparam int ANGR_W    = 25;
  localparam int LINR_W    = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPENING  = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

endpackage
`default_nettype wire

[design/snt_scan.sv]
// Scan tracker: first minimum of one scan and its index, latched at scan end.
// Depends on snt_pkg.
`default_nettype none
module snt_scan
  import snt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     sample_i,
  input  wire logic [DIST_W-1:0]        range_i,
  input  wire logic                     last_i,
  output logic signed [ANG_W-1:0]       target_angle_o,
  output logic [DIST_W-1:0]             target_dist_o
);

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [DIST_W-1:0] min_q, min_d;
  logic [IDX_W-1:0]  min_idx_q, min_idx_d;
  logic [DIST_W-1:0] r;

  always_comb begin
    r         = (range_i == '0) ? '1 : range_i;
    idx_d     = idx_q;
    min_d     = min_q;
    min_idx_d = min_idx_q;
    if (idx_q < IDX_W'(SCAN_LEN)) begin
      if (idx_q == '0 || r < min_q) begin
        min_d     = r;
        min_idx_d = idx_q;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      min_q          <= '1;
      min_idx_q      <= '0;
      target_angle_o <= '0;
      target_dist_o  <= '0;
    end else if (sample_i) begin
      if (last_i) begin
        if (min_idx_d > IDX_W'(SCAN_LEN / 2)) begin
          target_angle_o <= ANG_W'(min_idx_d) - ANG_W'(SCAN_LEN);
        end else begin
          target_angle_o <= ANG_W'(min_idx_d);
        end
        target_dist_o <= min_d;
        idx_q         <= '0;
        min_q         <= '1;
        min_idx_q     <= '0;
      end else begin
        idx_q     <= idx_d;
        min_q     <= min_d;
        min_idx_q <= min_idx_d;
      end
    end
  end

endmodule
`default_nettype wire

[design/snt_sqrt.sv]
// Digit-serial integer square root of (radicand << 10), two radicand bits per cycle.
// Depends on snt_pkg.
`default_nettype none
module snt_sqrt
  import snt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIST_W-1:0] radicand_i,
  output logic                   done_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic [RAD_W-1:0]  val_q;
  logic [REM_W-1:0]  rem_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  always_comb begin
    rem_sh = {rem_q, val_q[RAD_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_o, 2'b01});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      val_q  <= '0;
      rem_q  <= '0;
      root_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(ROOT_W);
        val_q  <= {radicand_i, {SQ_SHIFT{1'b0}}};
        rem_q  <= '0;
        root_o <= '0;
      end else if (busy_q) begin
        val_q <= {val_q[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= REM_W'(rem_sh - trial);
          root_o <= {root_o[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= REM_W'(rem_sh);
          root_o <= {root_o[ROOT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[design/snt_smul.sv]
// Bit-serial shift-add multiplier: gain times a 13-bit operand, one bit per cycle.
// Depends on snt_pkg.
`default_nettype none
module snt_smul
  import snt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [GAIN_W-1:0] a_i,
  input  wire logic [ROOT_W-1:0] b_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  logic [GAIN_W-1:0] a_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic [GAIN_W:0]   sum;

  assign sum = {1'b0, prod_o[PROD_W-1 -: GAIN_W]} +
               (prod_o[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      prod_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(ROOT_W);
        a_q    <= a_i;
        prod_o <= {{GAIN_W{1'b0}}, b_i};
      end else if (busy_q) begin
        prod_o <= {sum, prod_o[ROOT_W-1:1]};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[design/scan_nearest_target_follower.sv]
// Nearest-target follower: scan tracker plus digit-serial command generator.
// Depends on snt_pkg, snt_scan, snt_sqrt, snt_smul.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries cmd_i, range_i, last_i.
//   A sample transaction (cmd 0) gives no result; the sample with
//   last_i set closes the scan and latches the target.
//   A tick transaction (cmd 1) gives one result on the output channel
//   (out_valid_o/out_ready_i): angular_rate_o and linear_rate_o.
//   A tick runs from the accepting edge to out_valid_o through the square
//   root (two radicand bits per cycle), then the angular and linear
//   multiplies on the shared bit-serial multiplier.
//   Samples sustain one per cycle while no tick is in progress; after a tick
//   no input is taken until its result is registered.
//   The result register holds while the receiver stalls; samples are still
//   taken then, a further tick waits until the result is taken.
//   Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) is to be written only
//   while idle; the block itself does not enforce this. Reset restores
//   register defaults and an empty scan with target angle 0 and distance 0.
`default_nettype none
module scan_nearest_target_follower
  import snt_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      cmd_i,
  input  wire logic [DIST_W-1:0]         range_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [ANGR_W-1:0]       angular_rate_o,
  output logic [LINR_W-1:0]              linear_rate_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_W-1:0]          cfg_data_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_SQRT, ST_MUL_ANG, ST_MUL_LIN} state_e;

  state_e state_q;

  logic [DIST_W-1:0] min_dist_q;
  logic [GAIN_W-1:0] lin_gain_q;
  logic [GAIN_W-1:0] ang_gain_q;
  logic [OPEN_W-1:0] opening_q;

  logic                    in_acc;
  logic                    sample_acc;
  logic                    tick_acc;
  logic signed [ANG_W-1:0] tgt_angle;
  logic [DIST_W-1:0]       tgt_dist;
  logic [ANG_W-1:0]        mag;
  logic                    in_cone;
  logic [DIST_W-1:0]       diff;

  logic                    neg_q;
  logic [ANG_W-1:0]        mag_q;
  logic                    cone_q;
  logic [DIST_W-1:0]       diff_q;
  logic                    sq_start_q;
  logic                    sq_done;
  logic [ROOT_W-1:0]       root;
  logic                    mul_start_q;
  logic [GAIN_W-1:0]       mul_a_q;
  logic [ROOT_W-1:0]       mul_b_q;
  logic                    mul_done;
  logic [PROD_W-1:0]       prod;
  logic [ANGR_W-1:0]       ang_abs;

  assign in_ready_o = (state_q == ST_IDLE) && (cmd_i == CMD_SAMPLE || !out_valid_o);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sample_acc = in_acc && (cmd_i == CMD_SAMPLE);
  assign tick_acc   = in_acc && (cmd_i == CMD_TICK);

  assign mag     = tgt_angle[ANG_W-1] ? ANG_W'(-tgt_angle) : ANG_W'(tgt_angle);
  assign in_cone = 16'({mag, 1'b0}) < 16'(opening_q);
  assign diff    = (tgt_dist > min_dist_q) ? tgt_dist - min_dist_q : '0;
  assign ang_abs = prod[ANGR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= DIST_W'(205);
      lin_gain_q <= GAIN_W'(6554);
      ang_gain_q <= GAIN_W'(655);
      opening_q  <= OPEN_W'(40);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DIST: min_dist_q <= cfg_data_i[DIST_W-1:0];
        CFG_LIN_GAIN: lin_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ANG_GAIN: ang_gain_q <= cfg_data_i[GAIN_W-1:0];
        CFG_OPENING:  opening_q  <= cfg_data_i[OPEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      out_valid_o    <= 1'b0;
      angular_rate_o <= '0;
      linear_rate_o  <= '0;
      neg_q          <= 1'b0;
      mag_q          <= '0;
      cone_q         <= 1'b0;
      diff_q         <= '0;
      sq_start_q     <= 1'b0;
      mul_start_q    <= 1'b0;
      mul_a_q        <= '0;
      mul_b_q        <= '0;
    end else begin
      sq_start_q  <= 1'b0;
      mul_start_q <= 1'b0;
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (tick_acc) begin
            neg_q      <= tgt_angle[ANG_W-1];
            mag_q      <= mag;
            cone_q     <= in_cone;
            diff_q     <= diff;
            sq_start_q <= 1'b1;
            state_q    <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            mul_a_q     <= ang_gain_q;
            mul_b_q     <= ROOT_W'(mag_q);
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL_ANG;
          end
        end
        ST_MUL_ANG: begin
          if (mul_done) begin
            angular_rate_o <= neg_q ? -ang_abs : ang_abs;
            mul_a_q        <= lin_gain_q;
            mul_b_q        <= cone_q ? root : '0;
            mul_start_q    <= 1'b1;
            state_q        <= ST_MUL_LIN;
          end
        end
        ST_MUL_LIN: begin
          if (mul_done) begin
            linear_rate_o <= LINR_W'(prod);
            out_valid_o   <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  snt_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_acc),
    .range_i        (range_i),
    .last_i         (last_i),
    .target_angle_o (tgt_angle),
    .target_dist_o  (tgt_dist)
  );

  snt_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start_q),
    .radicand_i (diff_q),
    .done_o     (sq_done),
    .root_o     (root)
  );

  snt_smul u_smul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

endmodule
`default_nettype wire

[design/snt_checker.sv]
// Port-level checker for the nearest-target follower, bound to the top level.
// Depends on snt_pkg and scan_nearest_target_follower_assert.svh.
`default_nettype none
`include "scan_nearest_target_follower_assert.svh"
module snt_checker
  import snt_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  cmd_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [ANGR_W-1:0]     angular_rate_o,
  input wire logic [LINR_W-1:0]     linear_rate_o
);

  logic tick_acc;
  logic out_acc;
  logic out_stall;

  assign tick_acc  = in_valid_i && in_ready_o && (cmd_i == CMD_TICK);
  assign out_acc   = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;

  `SNT_ASSERT_IMP(a_tick_needs_free_out, clk_i, rst_ni, tick_acc, !out_valid_o)
  `SNT_ASSERT_NXT(a_tick_blocks_input, clk_i, rst_ni, tick_acc, !in_ready_o)
  `SNT_ASSERT_NXT(a_out_clears, clk_i, rst_ni, out_acc, !out_valid_o)
  `SNT_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_stall,
                  out_valid_o && $stable(angular_rate_o) && $stable(linear_rate_o))

endmodule

bind scan_nearest_target_follower snt_checker u_snt_checker (.*);
`default_nettype wire

[bench/target_command_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the nearest-target follower: tracks registers and scan state
// from observed transactions, predicts each tick's command, checks outputs.
// Depends on snt_pkg.
module target_command_checker
  import snt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic                     cmd_i,
  input  wire logic [DIST_W-1:0]        range_i,
  input  wire logic                     last_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic signed [ANGR_W-1:0] angular_rate_i,
  input  wire logic [LINR_W-1:0]        linear_rate_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  localparam logic [DIST_W-1:0] STANDOFF_RST = 16'd205;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 16'd6554;
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 16'd655;
  localparam logic [OPEN_W-1:0] CONE_RST     = 9'd40;

  typedef struct packed {
    logic signed [ANGR_W-1:0] angular;
    logic [LINR_W-1:0]        linear;
  } drive_cmd_t;

  logic [DIST_W-1:0]       stand_off;
  logic [GAIN_W-1:0]       lin_gain;
  logic [GAIN_W-1:0]       ang_gain;
  logic [OPEN_W-1:0]       cone;
  logic [IDX_W-1:0]        scan_pos;
  logic [IDX_W-1:0]        best_pos;
  logic [DIST_W-1:0]       best_range;
  logic [DIST_W-1:0]       tgt_dist;
  logic signed [ANG_W-1:0] tgt_angle;
  logic [DIST_W-1:0]       eff_range;
  int                      bearing;
  drive_cmd_t              exp_cmd;
  drive_cmd_t              command_queue[$];
  int                      fails = 0;
  int                      checked = 0;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [RAD_W-1:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (trial * trial <= 32'(v)) root = trial;
    end
    return root[ROOT_W-1:0];
  endfunction

  function automatic drive_cmd_t predict_command();
    drive_cmd_t        c;
    int                ang;
    int                mag;
    logic [DIST_W-1:0] diff;
    logic [31:0]       prod;
    ang = int'(tgt_angle) * int'(ang_gain);
    mag = (tgt_angle < 0) ? -int'(tgt_angle) : int'(tgt_angle);
    c.angular = ang[ANGR_W-1:0];
    c.linear = '0;
    // forward motion only inside the cone; below stand-off clamps to zero
    if (2 * mag < int'(cone)) begin
      diff = (tgt_dist > stand_off) ? tgt_dist - stand_off : '0;
      prod = 32'(floor_sqrt(RAD_W'(diff) << SQ_SHIFT)) * 32'(lin_gain);
      c.linear = prod[LINR_W-1:0];
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stand_off  = STANDOFF_RST;
      lin_gain   = LIN_GAIN_RST;
      ang_gain   = ANG_GAIN_RST;
      cone       = CONE_RST;
      scan_pos   = '0;
      best_pos   = '0;
      best_range = '1;
      tgt_dist   = '0;
      tgt_angle  = '0;
      command_queue.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (command_queue.size() == 0) begin
          $display("%0t: unexpected command, expected none, actual angular=%0d linear=%0d",
                   $time, angular_rate_i, linear_rate_i);
          fails++;
        end else begin
          exp_cmd = command_queue.pop_front();
          checked++;
          if (angular_rate_i !== exp_cmd.angular) begin
            $display("%0t: angular_rate mismatch, expected %0d actual %0d",
                     $time, $signed(exp_cmd.angular), angular_rate_i);
            fails++;
          end
          if (linear_rate_i !== exp_cmd.linear) begin
            $display("%0t: linear_rate mismatch, expected %0d actual %0d",
                     $time, exp_cmd.linear, linear_rate_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_TICK) begin
          command_queue.push_back(predict_command());
        end else begin
          eff_range = (range_i == '0) ? '1 : range_i;
          if (scan_pos < SCAN_LEN) begin
            if (scan_pos == '0 || eff_range < best_range) begin
              best_range = eff_range;
              best_pos   = scan_pos;
            end
            scan_pos = scan_pos + 1'b1;
          end
          if (last_i) begin
            bearing = int'(best_pos);
            if (bearing > SCAN_LEN / 2) bearing -= SCAN_LEN;
            tgt_angle  = bearing[ANG_W-1:0];
            tgt_dist   = best_range;
            scan_pos   = '0;
            best_range = '1;
            best_pos   = '0;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_DIST: stand_off = cfg_data_i[DIST_W-1:0];
          CFG_LIN_GAIN: lin_gain  = cfg_data_i[GAIN_W-1:0];
          CFG_ANG_GAIN: ang_gain  = cfg_data_i[GAIN_W-1:0];
          CFG_OPENING:  cone      = cfg_data_i[OPEN_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = command_queue.size();
  end

endmodule

[bench/tb_scan_nearest_target_follower.sv]
`timescale 1ns / 100ps
// Testbench top for scan_nearest_target_follower: clock, reset, register
// settings and scan/tick stimulus; verdict from target_command_checker.
// Depends on snt_pkg, the block and target_command_checker.
module tb_scan_nearest_target_follower;
  import snt_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int MIN_TICKS    = 60;
  localparam int PHASE_ITEMS  = 180;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_cmd = CMD_SAMPLE;
  logic [DIST_W-1:0]        in_range = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ANGR_W-1:0] angular_rate;
  logic [LINR_W-1:0]        linear_rate;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = CFG_MIN_DIST;
  logic [CFG_W-1:0]         cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int n_samples = 0;
  int n_ticks = 0;
  int n_scans = 0;
  int n_settings = 0;
  bit no_gaps = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  scan_nearest_target_follower dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (in_cmd),
    .range_i       (in_range),
    .last_i        (in_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .angular_rate_o(angular_rate),
    .linear_rate_o (linear_rate),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  target_command_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (in_cmd),
    .range_i       (in_range),
    .last_i        (in_last),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .angular_rate_i(angular_rate),
    .linear_rate_i (linear_rate),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: free-running, random, sparse and long-stall modes
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_left < 4);
    endcase
  end

  function automatic logic [DIST_W-1:0] pick_range();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return DIST_W'($urandom_range(1, 1024));
      default: return DIST_W'($urandom);
    endcase
  endfunction

  task automatic send_txn(input logic c, input logic [DIST_W-1:0] r, input logic l);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd   <= c;
    in_range <= r;
    in_last  <= l;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (c == CMD_TICK) n_ticks++;
    else n_samples++;
  endtask

  task automatic send_scan(input int len, input int plant_pos, input int tie_pos,
                           input logic [DIST_W-1:0] plant_val);
    logic [DIST_W-1:0] r;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3) send_txn(CMD_TICK, DIST_W'($urandom), 1'($urandom));
      r = (i == plant_pos || i == tie_pos) ? plant_val : pick_range();
      send_txn(CMD_SAMPLE, r, i == len - 1);
    end
    n_scans++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [CFG_W-1:0] sd, input logic [CFG_W-1:0] lg,
                                input logic [CFG_W-1:0] ag, input logic [CFG_W-1:0] oa);
    settle();
    write_reg(CFG_MIN_DIST, sd);
    write_reg(CFG_LIN_GAIN, lg);
    write_reg(CFG_ANG_GAIN, ag);
    write_reg(CFG_OPENING, oa);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int directed_items;
    int phase_start;
    int sel;
    int len;
    int plant;
    int tie;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, register defaults, no sender gaps
    no_gaps = 1'b1;
    send_txn(CMD_TICK, '1, 1'b1);              // tick before any scan
    send_txn(CMD_SAMPLE, '0, 1'b0);            // invalid range loads as largest
    send_txn(CMD_SAMPLE, '1, 1'b0);
    send_txn(CMD_SAMPLE, 16'd300, 1'b0);
    send_txn(CMD_SAMPLE, 16'd300, 1'b0);       // equal minimum, earliest wins
    send_txn(CMD_SAMPLE, 16'd500, 1'b1);
    send_txn(CMD_TICK, '0, 1'b0);
    send_txn(CMD_TICK, 16'h5A5A, 1'b1);        // back-to-back ticks
    send_txn(CMD_SAMPLE, '0, 1'b1);            // one-sample scan, invalid range
    send_txn(CMD_TICK, '0, 1'b0);
    send_txn(CMD_SAMPLE, 16'd100, 1'b1);       // below stand-off
    send_txn(CMD_TICK, 16'hA5A5, 1'b0);
    send_txn(CMD_SAMPLE, 16'd1, 1'b1);
    send_txn(CMD_TICK, '1, 1'b0);
    send_txn(CMD_SAMPLE, '1, 1'b1);
    send_txn(CMD_TICK, '0, 1'b1);
    send_txn(CMD_SAMPLE, 16'd4000, 1'b0);
    send_txn(CMD_SAMPLE, 16'd4000, 1'b0);
    send_txn(CMD_SAMPLE, 16'd2, 1'b1);
    send_txn(CMD_TICK, '0, 1'b0);
    directed_items = n_samples + n_ticks;
    no_gaps = 1'b0;

    // overlong scan: a minimum planted past the end must not count
    send_scan(SCAN_LEN + 5, SCAN_LEN + 2, -1, 16'd1);
    send_txn(CMD_TICK, '0, 1'b0);

    phase_start = -PHASE_ITEMS;
    while (n_samples + n_ticks - directed_items < RANDOM_ITEMS || n_ticks < MIN_TICKS) begin
      if (n_samples + n_ticks - phase_start >= PHASE_ITEMS) begin
        case (n_settings)
          0: write_settings('0, '0, '0, '0);
          1: write_settings('1, '1, '1, CFG_W'(SCAN_LEN));
          2: write_settings('0, '1, '1, CFG_W'(SCAN_LEN));
          default: write_settings($urandom_range(0, 1) ? CFG_W'($urandom_range(0, 2000))
                                                       : CFG_W'($urandom),
                                  CFG_W'($urandom), CFG_W'($urandom),
                                  CFG_W'($urandom_range(0, SCAN_LEN)));
        endcase
        phase_start = n_samples + n_ticks;
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 65) len = $urandom_range(1, 16);
      else if (sel < 90) len = $urandom_range(17, 64);
      else if (sel < 97) len = $urandom_range(150, SCAN_LEN);
      else len = $urandom_range(SCAN_LEN + 1, SCAN_LEN + 40);
      // plant near the end of the scan half the time to reach small negative angles
      if ($urandom_range(0, 1)) plant = len - 1 - $urandom_range(0, (len > 21) ? 20 : len - 1);
      else plant = $urandom_range(0, len - 1);
      tie = ($urandom_range(0, 3) == 0) ? $urandom_range(plant, len - 1) : -1;
      send_scan(len, plant, tie, DIST_W'($urandom_range(1, 3000)));
      repeat ($urandom_range(0, 4)) send_txn(CMD_TICK, DIST_W'($urandom), 1'($urandom));
    end

    settle();
    $display("Sent %0d samples (%0d random scans) and %0d ticks over %0d register settings.",
             n_samples, n_scans, n_ticks, n_settings);
    $display("Compared %0d commands with prediction, %0d failures.", checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/snt_pkg.sv
design/snt_scan.sv
design/snt_sqrt.sv
design/snt_smul.sv
design/scan_nearest_target_follower.sv
design/snt_checker.sv
bench/target_command_checker.sv
bench/tb_scan_nearest_target_follower.sv
